// ===== rtl/agbk_pkg.sv =====
`timescale 1ns / 1ps
package agbk_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;
    localparam logic [1:0] REG_PERIOD      = 2'd3;

    localparam int SET_FRAC  = 24;
    localparam int SET_WIDTH = 31;
    localparam int MEAS_WIDTH = 25;
    localparam int RATE_WIDTH = 28;
    localparam int ANGLE_LIM = 11796480;
    localparam int BIAS_LIM  = 131072000;

    // reset values of the settings
    localparam logic [30:0] ANGLE_NOISE_RST = 31'd3187671;
    localparam logic [30:0] BIAS_NOISE_RST  = 31'd13925089;
    localparam logic [30:0] MEAS_NOISE_RST  = 31'd8388608;
    localparam logic [30:0] PERIOD_RST      = 31'd16777;

    // operand selects for the shared multiplier
    typedef enum logic [3:0] {
        OP_RATE_DT, OP_PD0_DT, OP_P11_DT, OP_QG_DT,
        OP_K0_T0, OP_K0_T1, OP_K1_T0, OP_K1_T1, OP_K0_ERR, OP_K1_ERR
    } mul_op_t;

    // datapath step commands
    typedef enum logic [3:0] {
        CMD_NONE, CMD_LOAD, CMD_PD0, CMD_MUL, CMD_ERR_E, CMD_DIV0, CMD_DIV1,
        CMD_OUT
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t cmd;
        mul_op_t op;
    } ctrl_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic e_zero;
    } stat_t;

endpackage

// ===== rtl/agbk_mul.sv =====
`timescale 1ns / 1ps
// sequential signed multiply: round(a*b/2^FRAC) ties away, saturated
module agbk_mul #(
    parameter int DATA_WIDTH    = 32,
    parameter int COV_FRAC_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [DATA_WIDTH-1:0] a,
    input  logic signed [DATA_WIDTH-1:0] b,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] y
);
    localparam int HW  = (DATA_WIDTH + 1) / 2;
    localparam int PW  = 2 * DATA_WIDTH;
    localparam logic [DATA_WIDTH-1:0] MAXP = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    typedef enum logic [2:0] {S_IDLE, S_LO, S_HI, S_RND, S_SAT} st_t;
    st_t st_reg;
    logic [DATA_WIDTH-1:0] ua_reg, ub_reg;
    logic                  neg_reg;
    logic [PW:0]           acc_reg;
    logic [DATA_WIDTH-1:0] y_reg;
    logic                  done_reg;

    logic [DATA_WIDTH-1:0] ma, mb;
    logic [HW-1:0]         bsel;
    logic [DATA_WIDTH+HW-1:0] part;
    logic [PW:0]           rnd, shf;
    logic [DATA_WIDTH:0]   mag;

    assign ma = a[DATA_WIDTH-1] ? DATA_WIDTH'(-a) : DATA_WIDTH'(a);
    assign mb = b[DATA_WIDTH-1] ? DATA_WIDTH'(-b) : DATA_WIDTH'(b);
    // half of b per cycle keeps the multiplier narrow
    assign bsel = (st_reg == S_LO) ? ub_reg[HW-1:0]
                                   : HW'(ub_reg >> HW);
    assign part = (DATA_WIDTH+HW)'(ua_reg) * (DATA_WIDTH+HW)'(bsel);
    assign rnd  = acc_reg + ((PW+1)'(1) << (COV_FRAC_BITS - 1));
    assign shf  = rnd >> COV_FRAC_BITS;
    // magnitude cap above the positive limit keeps the negative limit reachable
    assign mag  = (shf > (PW+1)'(MAXP) + 1) ? (DATA_WIDTH+1)'(MAXP) + 1
                                            : (DATA_WIDTH+1)'(shf);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE: if (start) begin
                    ua_reg  <= ma;
                    ub_reg  <= mb;
                    neg_reg <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
                    st_reg  <= S_LO;
                end
                S_LO: begin
                    acc_reg <= (PW+1)'(part);
                    st_reg  <= S_HI;
                end
                S_HI: begin
                    acc_reg <= acc_reg + ((PW+1)'(part) << HW);
                    st_reg  <= S_RND;
                end
                S_RND: begin
                    acc_reg <= (PW+1)'(mag);
                    st_reg  <= S_SAT;
                end
                S_SAT: begin
                    if (neg_reg)
                        y_reg <= DATA_WIDTH'(-acc_reg[DATA_WIDTH:0]);
                    else if (acc_reg[DATA_WIDTH:0] > (DATA_WIDTH+1)'(MAXP))
                        y_reg <= MAXP;
                    else
                        y_reg <= acc_reg[DATA_WIDTH-1:0];
                    done_reg <= 1'b1;
                    st_reg   <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign y    = y_reg;
endmodule

// ===== rtl/agbk_div.sv =====
`timescale 1ns / 1ps
// restoring divider: (n << FRAC) / d truncated toward zero, saturated
module agbk_div #(
    parameter int DATA_WIDTH    = 32,
    parameter int COV_FRAC_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [DATA_WIDTH-1:0] n,
    input  logic signed [DATA_WIDTH-1:0] d,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] y
);
    localparam int QW = DATA_WIDTH + COV_FRAC_BITS;
    localparam int CW = $clog2(QW + 1);
    localparam logic [DATA_WIDTH-1:0] MAXP = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    logic              busy_reg, done_reg, neg_reg;
    logic [CW-1:0]     cnt_reg;
    logic [QW-1:0]     num_reg, q_reg;
    logic [DATA_WIDTH:0] r_reg, ud_reg;
    logic [DATA_WIDTH-1:0] y_reg;
    logic [DATA_WIDTH:0] rs;

    assign rs = {r_reg[DATA_WIDTH-1:0], num_reg[QW-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW);
                // magnitudes taken one bit wider so the most negative value fits
                num_reg  <= QW'(n[DATA_WIDTH-1] ? -(DATA_WIDTH+1)'(n)
                                                : (DATA_WIDTH+1)'(n)) << COV_FRAC_BITS;
                ud_reg   <= d[DATA_WIDTH-1] ? -(DATA_WIDTH+1)'(d) : (DATA_WIDTH+1)'(d);
                neg_reg  <= n[DATA_WIDTH-1] ^ d[DATA_WIDTH-1];
                r_reg    <= '0;
                q_reg    <= '0;
            end else if (busy_reg) begin
                // one quotient bit per cycle
                if (cnt_reg != '0) begin
                    num_reg <= num_reg << 1;
                    if (rs >= ud_reg) begin
                        r_reg <= rs - ud_reg;
                        q_reg <= {q_reg[QW-2:0], 1'b1};
                    end else begin
                        r_reg <= rs;
                        q_reg <= {q_reg[QW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                end else begin
                    if (neg_reg)
                        y_reg <= (q_reg > QW'(MAXP)) ? ~MAXP : DATA_WIDTH'(-q_reg);
                    else
                        y_reg <= (q_reg > QW'(MAXP)) ? MAXP : q_reg[DATA_WIDTH-1:0];
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign y    = y_reg;
endmodule

// ===== rtl/agbk_datapath.sv =====
`timescale 1ns / 1ps
// filter state, settings, shared multiplier and divider
module agbk_datapath #(
    parameter int DATA_WIDTH    = 32,
    parameter int COV_FRAC_BITS = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  agbk_pkg::ctrl_t        ctrl,
    output agbk_pkg::stat_t        stat,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_idx,
    input  logic [30:0]            cfg_data,
    output logic [30:0]            cfg_rdata,
    input  logic signed [24:0]     meas_in,
    input  logic signed [27:0]     rate_in,
    output logic signed [24:0]     angle_out,
    output logic signed [27:0]     bias_out,
    output logic                   held_out
);
    localparam int DW = DATA_WIDTH;
    localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] ONE  = DW'(1) << COV_FRAC_BITS;

    logic [30:0] qa_cfg_reg, qg_cfg_reg, rn_cfg_reg, dt_cfg_reg;
    logic signed [DW-1:0] ang_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [DW-1:0] k0_reg, k1_reg, t0_reg, t1_reg, c11_reg;
    logic signed [DW-1:0] err_reg, e_reg, pd0_reg;
    logic signed [DW-1:0] meas_reg, rate_reg;
    logic held_reg;
    logic signed [DW-1:0] qa, qg, rn, dt;
    logic signed [DW-1:0] ma, mb, my, dn, dy;
    logic                 mdone, ddone;

    // align unsigned Q7.24 settings to the covariance format
    function automatic logic signed [DW-1:0] setting(input logic [30:0] r);
        logic [DW+38:0] v;
        if (COV_FRAC_BITS >= agbk_pkg::SET_FRAC)
            v = (DW+39)'(r) << (COV_FRAC_BITS - agbk_pkg::SET_FRAC);
        else
            v = (DW+39)'(r) >> (agbk_pkg::SET_FRAC - COV_FRAC_BITS);
        return (v > (DW+39)'(MAXV)) ? MAXV : DW'(v);
    endfunction

    function automatic logic signed [DW-1:0] sadd(input logic signed [DW-1:0] x,
                                                  input logic signed [DW-1:0] z);
        logic signed [DW:0] s;
        s = (DW+1)'(x) + (DW+1)'(z);
        if (s > (DW+1)'(MAXV)) return MAXV;
        if (s < (DW+1)'(MINV)) return MINV;
        return DW'(s);
    endfunction

    function automatic logic signed [DW-1:0] ssub(input logic signed [DW-1:0] x,
                                                  input logic signed [DW-1:0] z);
        logic signed [DW:0] s;
        s = (DW+1)'(x) - (DW+1)'(z);
        if (s > (DW+1)'(MAXV)) return MAXV;
        if (s < (DW+1)'(MINV)) return MINV;
        return DW'(s);
    endfunction

    assign qa = setting(qa_cfg_reg);
    assign qg = setting(qg_cfg_reg);
    assign rn = setting(rn_cfg_reg);
    assign dt = setting(dt_cfg_reg);

    // multiplier operand select
    always_comb begin
        ma = k0_reg;
        mb = t0_reg;
        case (ctrl.op)
            agbk_pkg::OP_RATE_DT: begin ma = ssub(rate_reg, bias_reg); mb = dt; end
            agbk_pkg::OP_PD0_DT:  begin ma = pd0_reg; mb = dt; end
            agbk_pkg::OP_P11_DT:  begin ma = c11_reg; mb = dt; end
            agbk_pkg::OP_QG_DT:   begin ma = qg; mb = dt; end
            agbk_pkg::OP_K0_T0:   begin ma = k0_reg; mb = t0_reg; end
            agbk_pkg::OP_K0_T1:   begin ma = k0_reg; mb = t1_reg; end
            agbk_pkg::OP_K1_T0:   begin ma = k1_reg; mb = t0_reg; end
            agbk_pkg::OP_K1_T1:   begin ma = k1_reg; mb = t1_reg; end
            agbk_pkg::OP_K0_ERR:  begin ma = k0_reg; mb = err_reg; end
            agbk_pkg::OP_K1_ERR:  begin ma = k1_reg; mb = err_reg; end
            default: ;
        endcase
    end

    agbk_mul #(.DATA_WIDTH(DW), .COV_FRAC_BITS(COV_FRAC_BITS)) u_mul (
        .aclk(aclk), .aresetn(aresetn),
        .start(ctrl.cmd == agbk_pkg::CMD_MUL),
        .a(ma), .b(mb), .done(mdone), .y(my)
    );

    assign dn = (ctrl.cmd == agbk_pkg::CMD_DIV1) ? p10_reg : p00_reg;
    agbk_div #(.DATA_WIDTH(DW), .COV_FRAC_BITS(COV_FRAC_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn),
        .start(ctrl.cmd == agbk_pkg::CMD_DIV0 || ctrl.cmd == agbk_pkg::CMD_DIV1),
        .n(dn), .d(e_reg), .done(ddone), .y(dy)
    );

    assign stat.mul_done = mdone;
    assign stat.div_done = ddone;
    assign stat.e_zero   = (e_reg == '0);

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qa_cfg_reg <= agbk_pkg::ANGLE_NOISE_RST;
            qg_cfg_reg <= agbk_pkg::BIAS_NOISE_RST;
            rn_cfg_reg <= agbk_pkg::MEAS_NOISE_RST;
            dt_cfg_reg <= agbk_pkg::PERIOD_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                agbk_pkg::REG_ANGLE_NOISE: qa_cfg_reg <= cfg_data;
                agbk_pkg::REG_BIAS_NOISE:  qg_cfg_reg <= cfg_data;
                agbk_pkg::REG_MEAS_NOISE:  rn_cfg_reg <= cfg_data;
                agbk_pkg::REG_PERIOD:      dt_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            agbk_pkg::REG_ANGLE_NOISE: cfg_rdata = qa_cfg_reg;
            agbk_pkg::REG_BIAS_NOISE:  cfg_rdata = qg_cfg_reg;
            agbk_pkg::REG_MEAS_NOISE:  cfg_rdata = rn_cfg_reg;
            default:                   cfg_rdata = dt_cfg_reg;
        endcase
    end

    // filter state update, one step per command
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ang_reg  <= '0;
            bias_reg <= '0;
            p00_reg  <= ONE;
            p01_reg  <= '0;
            p10_reg  <= '0;
            p11_reg  <= ONE;
            k0_reg   <= '0;
            k1_reg   <= '0;
            held_reg <= 1'b0;
        end else begin
            unique case (ctrl.cmd)
                agbk_pkg::CMD_LOAD: begin
                    meas_reg <= DW'(meas_in);
                    rate_reg <= DW'(rate_in);
                    c11_reg  <= p11_reg;
                end
                agbk_pkg::CMD_PD0: pd0_reg <= ssub(ssub(qa, p01_reg), p10_reg);
                agbk_pkg::CMD_ERR_E: begin
                    err_reg <= ssub(meas_reg, ang_reg);
                    e_reg   <= sadd(rn, p00_reg);
                    t0_reg  <= p00_reg;
                    t1_reg  <= p01_reg;
                    held_reg <= 1'b1;
                end
                agbk_pkg::CMD_DIV0: held_reg <= 1'b0;
                default: ;
            endcase
            if (mdone) begin
                case (ctrl.op)
                    agbk_pkg::OP_RATE_DT: ang_reg <= sadd(ang_reg, my);
                    agbk_pkg::OP_PD0_DT:  p00_reg <= sadd(p00_reg, my);
                    agbk_pkg::OP_P11_DT: begin
                        p01_reg <= ssub(p01_reg, my);
                        p10_reg <= ssub(p10_reg, my);
                    end
                    agbk_pkg::OP_QG_DT:  p11_reg <= sadd(p11_reg, my);
                    agbk_pkg::OP_K0_T0:  p00_reg <= ssub(p00_reg, my);
                    agbk_pkg::OP_K0_T1:  p01_reg <= ssub(p01_reg, my);
                    agbk_pkg::OP_K1_T0:  p10_reg <= ssub(p10_reg, my);
                    agbk_pkg::OP_K1_T1:  p11_reg <= ssub(p11_reg, my);
                    agbk_pkg::OP_K0_ERR: ang_reg <= sadd(ang_reg, my);
                    agbk_pkg::OP_K1_ERR: bias_reg <= sadd(bias_reg, my);
                    default: ;
                endcase
            end
            if (ddone) begin
                if (ctrl.cmd == agbk_pkg::CMD_NONE && ctrl.op == agbk_pkg::OP_K0_T0)
                    k0_reg <= dy;
                else
                    k1_reg <= dy;
            end
        end
    end

    // clamp to the output ranges
    always_comb begin
        if (ang_reg > DW'(agbk_pkg::ANGLE_LIM))       angle_out = 25'(agbk_pkg::ANGLE_LIM);
        else if (ang_reg < -DW'(agbk_pkg::ANGLE_LIM)) angle_out = 25'(-agbk_pkg::ANGLE_LIM);
        else                                          angle_out = 25'(ang_reg);
        if (bias_reg > DW'(agbk_pkg::BIAS_LIM))       bias_out = 28'(agbk_pkg::BIAS_LIM);
        else if (bias_reg < -DW'(agbk_pkg::BIAS_LIM)) bias_out = 28'(-agbk_pkg::BIAS_LIM);
        else                                          bias_out = 28'(bias_reg);
    end
    assign held_out = held_reg;
endmodule

// ===== rtl/agbk_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer over one filter step
module agbk_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_fire,
    input  logic             out_free,
    input  agbk_pkg::stat_t  stat,
    output agbk_pkg::ctrl_t  ctrl,
    output logic             busy,
    output logic             out_load
);
    typedef enum logic [3:0] {
        S_IDLE, S_PD0, S_MSTART, S_MWAIT, S_ERR, S_CHK, S_D0, S_D0W, S_D1, S_D1W,
        S_OUT
    } st_t;
    st_t st_reg;
    agbk_pkg::mul_op_t op_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            op_reg <= agbk_pkg::OP_RATE_DT;
        end else begin
            unique case (st_reg)
                S_IDLE: if (in_fire) begin
                    st_reg <= S_PD0;
                    op_reg <= agbk_pkg::OP_RATE_DT;
                end
                S_PD0:    st_reg <= S_MSTART;
                S_MSTART: st_reg <= S_MWAIT;
                S_MWAIT: if (stat.mul_done) begin
                    unique case (op_reg)
                        agbk_pkg::OP_QG_DT: st_reg <= S_ERR;
                        agbk_pkg::OP_K1_ERR: st_reg <= S_OUT;
                        default: begin
                            op_reg <= agbk_pkg::mul_op_t'(op_reg + 1'b1);
                            st_reg <= S_MSTART;
                        end
                    endcase
                end
                S_ERR: st_reg <= S_CHK;
                S_CHK: begin
                    op_reg <= agbk_pkg::OP_K0_T0;
                    st_reg <= stat.e_zero ? S_MSTART : S_D0;
                end
                S_D0: st_reg <= S_D0W;
                S_D0W: if (stat.div_done) st_reg <= S_D1;
                S_D1: begin
                    op_reg <= agbk_pkg::OP_K0_ERR;
                    st_reg <= S_D1W;
                end
                S_D1W: if (stat.div_done) begin
                    op_reg <= agbk_pkg::OP_K0_T0;
                    st_reg <= S_MSTART;
                end
                S_OUT: if (out_free) st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        ctrl.op = op_reg;
        unique case (st_reg)
            S_IDLE:   ctrl.cmd = in_fire ? agbk_pkg::CMD_LOAD : agbk_pkg::CMD_NONE;
            S_PD0:    ctrl.cmd = agbk_pkg::CMD_PD0;
            S_MSTART: ctrl.cmd = agbk_pkg::CMD_MUL;
            S_ERR:    ctrl.cmd = agbk_pkg::CMD_ERR_E;
            S_D0:     ctrl.cmd = agbk_pkg::CMD_DIV0;
            S_D1:     ctrl.cmd = agbk_pkg::CMD_DIV1;
            S_OUT:    ctrl.cmd = agbk_pkg::CMD_OUT;
            default:  ctrl.cmd = agbk_pkg::CMD_NONE;
        endcase
    end

    assign busy     = (st_reg != S_IDLE);
    assign out_load = (st_reg == S_OUT) && out_free;
endmodule

// ===== rtl/angle_gyro_bias_kalman_core.sv =====
`timescale 1ns / 1ps
// Two-state Kalman filter on tilt angle and gyro bias. Each accepted sample
// (accelerometer angle, gyro rate) gives one result: the saturated angle and
// bias estimates and a flag set when the innovation variance was zero and the
// previous gains were kept. One shared sequential multiplier (ten products)
// and one restoring divider (two gains, skipped when the gains are held) do
// the arithmetic; a stalled result side holds the step in its last state.
// The next sample is taken once the previous result has moved into the
// output register. Settings sit on an APB port at byte addresses 0, 4, 8
// and 12.
module angle_gyro_bias_kalman_core #(
    parameter int DATA_WIDTH    = 32,
    parameter int COV_FRAC_BITS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [24:0] s_measured_angle,
    input  logic signed [27:0] s_gyro_rate,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [24:0] m_angle_estimate,
    output logic signed [27:0] m_rate_bias,
    output logic               m_gain_held
);
    agbk_pkg::ctrl_t ctrl;
    agbk_pkg::stat_t stat;
    logic busy, out_load, in_fire, out_free;
    logic [30:0] cfg_rdata;
    logic signed [24:0] ang_w;
    logic signed [27:0] bias_w;
    logic held_w;
    logic m_valid_reg;
    logic signed [24:0] ang_reg;
    logic signed [27:0] bias_reg;
    logic held_reg;

    assign pready   = 1'b1;
    assign prdata   = {1'b0, cfg_rdata};
    assign s_ready  = !busy;
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    agbk_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .out_free(out_free),
        .stat(stat), .ctrl(ctrl), .busy(busy), .out_load(out_load)
    );

    agbk_datapath #(.DATA_WIDTH(DATA_WIDTH), .COV_FRAC_BITS(COV_FRAC_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl), .stat(stat),
        .cfg_we(psel && penable && pwrite && pready),
        .cfg_idx(paddr[3:2]), .cfg_data(pwdata[30:0]), .cfg_rdata(cfg_rdata),
        .meas_in(s_measured_angle), .rate_in(s_gyro_rate),
        .angle_out(ang_w), .bias_out(bias_w), .held_out(held_w)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
                ang_reg  <= ang_w;
                bias_reg <= bias_w;
                held_reg <= held_w;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_angle_estimate = ang_reg;
    assign m_rate_bias      = bias_reg;
    assign m_gain_held      = held_reg;

`ifndef NO_ASSERTIONS
    // no new sample while a step is running
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_ready) else $error("sample accepted during a step");
    // a held result is not overwritten
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_angle_estimate) && m_valid)
        else $error("result changed while stalled");
    // multiplier and divider never finish together
    a_units: assert property (@(posedge aclk) disable iff (!aresetn)
        !(stat.mul_done && stat.div_done)) else $error("unit overlap");
`endif
endmodule
